>>> sv/diff_drive_odometry_unit_defines.svh
// Assertion macros for the odometry unit.
// No dependencies; included by the top level.
`ifndef DIFF_DRIVE_ODOMETRY_UNIT_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_UNIT_DEFINES_SVH

// same-cycle implication
`define DDO_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("odometry assertion failed");

// next-cycle implication
`define DDO_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("odometry assertion failed");

`endif

>>> sv/ddo_pkg.sv
// Shared types, op codes and constants of the odometry unit.
// No dependencies.
`timescale 1ns / 1ps
package ddo_pkg;

  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_QR     = 4'd2;
  localparam logic [3:0] OP_M1     = 4'd3;
  localparam logic [3:0] OP_M2     = 4'd4;
  localparam logic [3:0] OP_M3     = 4'd5;
  localparam logic [3:0] OP_M4     = 4'd6;
  localparam logic [3:0] OP_M5     = 4'd7;
  localparam logic [3:0] OP_RGST   = 4'd8;
  localparam logic [3:0] OP_SQ     = 4'd9;
  localparam logic [3:0] OP_X1     = 4'd10;
  localparam logic [3:0] OP_X2     = 4'd11;
  localparam logic [3:0] OP_X3     = 4'd12;
  localparam logic [3:0] OP_RESULT = 4'd13;

  // about 2^50/pi, heading units per wheel-base ratio with 20 fraction bits
  localparam logic [48:0] TURN_GAIN = 49'd358385071201434;
  // travel scale: (m*2^16 + 1000) / 2000 == (m*2^12 + 62) / 125
  localparam logic [14:0] TRAVEL_DIV = 15'd125;
  localparam logic [15:0] TRAVEL_RECIP = 16'd33555;   // ceil(2^22 / 125)
  localparam logic [11:0] TRAVEL_BIAS = 12'd62;
  localparam logic [11:0] WHEEL_BASE_RESET = 12'd248;
  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
  localparam logic [30:0] ANG_PI = 31'h40000000;
  localparam logic [30:0] ANG_HALF_PI = 31'h20000000;

  localparam int DIV_B_W = 61;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic div_a_busy;
    logic div_b_busy;
    logic cordic_busy;
  } status_t;

  function automatic logic [28:0] atan_units(input logic [4:0] idx);
    logic [28:0] v;
    case (idx)
      5'd0:  v = 29'd268435456;
      5'd1:  v = 29'd158466703;
      5'd2:  v = 29'd83729454;
      5'd3:  v = 29'd42502378;
      5'd4:  v = 29'd21333665;
      5'd5:  v = 29'd10677233;
      5'd6:  v = 29'd5339919;
      5'd7:  v = 29'd2670123;
      5'd8:  v = 29'd1335082;
      5'd9:  v = 29'd667543;
      5'd10: v = 29'd333772;
      5'd11: v = 29'd166886;
      5'd12: v = 29'd83443;
      5'd13: v = 29'd41722;
      5'd14: v = 29'd20861;
      5'd15: v = 29'd10430;
      5'd16: v = 29'd5215;
      5'd17: v = 29'd2608;
      5'd18: v = 29'd1304;
      5'd19: v = 29'd652;
      5'd20: v = 29'd326;
      5'd21: v = 29'd163;
      5'd22: v = 29'd81;
      5'd23: v = 29'd41;
      5'd24: v = 29'd20;
      5'd25: v = 29'd10;
      5'd26: v = 29'd5;
      5'd27: v = 29'd3;
      5'd28: v = 29'd1;
      5'd29: v = 29'd1;
      default: v = 29'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/diff_drive_odometry_unit.sv
// Each word runs two divider passes and two CORDIC runs before its result is
// valid. A new word is taken once the previous one is in the output register,
// even while it waits.
// Reset (rst_n low, synchronous): pose, heading and previous readings cleared,
// wheel base back to 248 mm, no result pending. No clearing pass.
`timescale 1ns / 1ps
`include "diff_drive_odometry_unit_defines.svh"
module diff_drive_odometry_unit import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input words: cumulative wheel travel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_left_travel_mm,
  input  logic signed [31:0] in_right_travel_mm,
  // result words: pose and heading quaternion
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [31:0]        out_heading_angle,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  // wheel base register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [11:0]        cfg_wheel_base_mm
);
  cmd_t    cmd;
  status_t status;

  // register writes are always taken; host only writes while idle
  assign cfg_ready = 1'b1;

  // sequencer: at most one op per state, waits on unit busy flags
  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: travel scaling runs alongside the turn divider,
  // then gain multiply, remainder divide, midpoint CORDIC, pose update, quaternion CORDIC
  ddo_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_left     (in_left_travel_mm),
    .in_right    (in_right_travel_mm),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_wb      (cfg_wheel_base_mm),
    .res_x       (out_pos_x),
    .res_y       (out_pos_y),
    .res_heading (out_heading_angle),
    .res_qz      (out_quat_z),
    .res_qw      (out_quat_w)
  );

  // an accepted word keeps the input side closed while it is worked on
  `DDO_ASSERT_NXT(a_accept_closes, clk, rst_n, in_valid && !in_stall, in_stall)
  // the units only run while a word is in flight
  `DDO_ASSERT_IMP(a_cordic_inflight, clk, rst_n, status.cordic_busy, in_stall)
  `DDO_ASSERT_IMP(a_div_inflight, clk, rst_n, status.div_b_busy || status.div_a_busy, in_stall)
endmodule

>>> sv/ddo_div.sv
// Restoring divider, one quotient bit per cycle, 12-bit divisor.
// Depends on nothing.
`timescale 1ns / 1ps
module ddo_div #(
  parameter int W = 49
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [11:0]  divisor,
  output logic         busy,
  output logic [W-1:0] quot,
  output logic [11:0]  rem
);
  localparam int CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic [11:0]   p_r, p_nxt;
  logic [11:0]   d_r, d_nxt;
  logic [12:0]   trial;

  assign trial = {p_r, q_r[W-1]};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    p_nxt    = p_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W - 1);
      q_nxt    = dividend;
      p_nxt    = 12'd0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        p_nxt = 12'(trial - {1'b0, d_r});
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        p_nxt = trial[11:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    p_r <= p_nxt;
    d_r <= d_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign rem  = p_r;
endmodule

>>> sv/ddo_cordic.sv
// Iterative rotation-mode CORDIC, sine and cosine in Q2.30.
// Depends on ddo_pkg (arctangent table, start vector).
`timescale 1ns / 1ps
module ddo_cordic import ddo_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               busy,
  output logic signed [32:0] sin_q30,
  output logic signed [32:0] cos_q30
);
  localparam int IW = $clog2(STEPS);

  logic              busy_r, busy_nxt;
  logic [IW-1:0]     cnt_r, cnt_nxt;
  logic signed [32:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic              neg_r, neg_nxt;
  logic [30:0]       z1;
  logic              n1, n2;
  logic signed [32:0] xs, ys, at;

  always_comb begin
    n1 = angle[30:0] >= ANG_PI;
    z1 = n1 ? angle[30:0] - ANG_PI : angle[30:0];
    n2 = z1 >= ANG_HALF_PI;
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    at = $signed({4'd0, atan_units(5'(cnt_r))});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = CORDIC_START;
      y_nxt    = '0;
      // fold into [-pi/2, pi/2), sign of the result flips per fold
      z_nxt    = n2 ? $signed({2'b0, z1}) - $signed({2'b0, ANG_PI})
                    : $signed({2'b0, z1});
      neg_nxt  = n1 ^ n2;
    end else if (busy_r) begin
      if (!z_r[32]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == IW'(STEPS - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    neg_r <= neg_nxt;
  end

  assign busy    = busy_r;
  assign sin_q30 = neg_r ? -y_r : y_r;
  assign cos_q30 = neg_r ? -x_r : x_r;
endmodule

>>> sv/ddo_datapath.sv
// Odometry datapath: pose state, dividers, shared multiplier, CORDIC.
// Depends on ddo_pkg, ddo_div, ddo_cordic.
`timescale 1ns / 1ps
module ddo_datapath import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic signed [31:0]  in_left,
  input  logic signed [31:0]  in_right,
  input  logic                cfg_we,
  input  logic [11:0]         cfg_wb,
  output logic signed [31:0]  res_x,
  output logic signed [31:0]  res_y,
  output logic [31:0]         res_heading,
  output logic signed [15:0]  res_qz,
  output logic signed [15:0]  res_qw
);
  localparam logic [2:0] TRAVEL_LAST = 3'd5;   // six quotient bytes

  logic [11:0] wb_r, wb_eff;
  logic [31:0] prev_l_r, prev_r_r;
  logic signed [31:0] acc_x_r, acc_y_r;
  logic [31:0] head_r, dunits_r;
  logic sum_neg_r, diff_neg_r;
  logic signed [33:0] q_r;
  logic [11:0] r_r;
  logic signed [65:0] prod_r;
  logic [63:0] sq_r;
  logic [60:0] rg_r;
  logic signed [38:0] travel_r;
  logic signed [31:0] ox_r, oy_r;
  logic [31:0] oh_r;
  logic signed [15:0] oz_r, ow_r;
  logic [47:0] tn_r, tq_r;
  logic [6:0]  trem_r;
  logic [2:0]  tcnt_r;
  logic        tbusy_r;

  logic signed [31:0] dl, dr;
  logic signed [32:0] sum, diff;
  logic [32:0] sum_mag, diff_mag;
  logic a_start, b_start, a_busy, b_busy;
  logic [DIV_B_W-1:0] b_quot, b_dvd;
  logic [11:0] b_rem;
  logic [14:0] t_dig, t_back;
  logic [30:0] t_mul;
  logic [7:0]  t_qd;
  logic signed [39:0] mul_a;
  logic signed [25:0] mul_b;
  logic mul_en;
  logic [63:0] sq_fin, t19, t20;
  logic [31:0] halfmid, head_new;
  logic c_start, c_busy;
  logic [31:0] c_ang;
  logic signed [32:0] s30, c30, s_rnd, c_rnd;
  logic signed [18:0] s16, c16;
  logic signed [65:0] prod_rnd;
  logic signed [49:0] dpos, npos;
  logic signed [33:0] qm_pos;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
    logic signed [32:0] t;
    logic signed [17:0] sh;
    logic signed [15:0] r;
    t  = v + 33'sd16384;
    sh = t[32:15];
    if (sh > 18'sd32767) r = 16'sh7FFF;
    else if (sh < -18'sd32768) r = 16'sh8000;
    else r = sh[15:0];
    return r;
  endfunction

  assign wb_eff = (wb_r == 12'd0) ? 12'd1 : wb_r;

  // wheel deltas with 32-bit wrap
  assign dl = $signed(in_left - prev_l_r);
  assign dr = $signed(in_right - prev_r_r);
  assign sum  = 33'(dl) + 33'(dr);
  assign diff = 33'(dr) - 33'(dl);
  assign sum_mag  = sum[32] ? 33'(-sum) : 33'(sum);
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

  assign a_start = (cmd.op == OP_LOAD);
  assign b_start = (cmd.op == OP_LOAD) || (cmd.op == OP_RGST);
  assign b_dvd   = (cmd.op == OP_LOAD) ? DIV_B_W'(diff_mag) : rg_r;

  // travel scale by 125, one quotient byte per cycle;
  // each digit via reciprocal multiply, exact for digits below 32768
  assign t_dig  = {trem_r, tn_r[47:40]};
  assign t_mul  = t_dig * TRAVEL_RECIP;
  assign t_qd   = t_mul[29:22];
  assign t_back = t_dig - {7'd0, t_qd} * TRAVEL_DIV;
  assign a_busy = tbusy_r;

  ddo_div #(.W(DIV_B_W)) u_div_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (b_start),
    .dividend (b_dvd),
    .divisor  (wb_eff),
    .busy     (b_busy),
    .quot     (b_quot),
    .rem      (b_rem)
  );

  // heading change and midpoint offset
  assign sq_fin   = sq_r + {15'd0, b_quot[48:0]};
  assign t19      = sq_fin + 64'h80000;
  assign t20      = sq_fin + 64'h100000;
  assign halfmid  = t20[52:21];
  assign head_new = head_r + dunits_r;

  assign c_start = (cmd.op == OP_SQ) || (cmd.op == OP_X3);
  assign c_ang   = (cmd.op == OP_SQ) ? head_r + halfmid : {1'b0, head_new[31:1]};

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (c_start),
    .angle   (c_ang),
    .busy    (c_busy),
    .sin_q30 (s30),
    .cos_q30 (c30)
  );

  assign s_rnd = s30 + 33'sd8192;
  assign c_rnd = c30 + 33'sd8192;
  assign s16   = s_rnd[32:14];
  assign c16   = c_rnd[32:14];

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = 40'(q_r);
    mul_b  = $signed({1'b0, TURN_GAIN[24:0]});
    case (cmd.op)
      OP_M1: ;
      OP_M2: mul_b = $signed({2'b0, TURN_GAIN[48:25]});
      OP_M3: mul_a = $signed({28'd0, r_r});
      OP_M4: begin
        mul_a = $signed({28'd0, r_r});
        mul_b = $signed({2'b0, TURN_GAIN[48:25]});
      end
      OP_X1: begin
        mul_a = 40'(travel_r);
        mul_b = 26'(c16);
      end
      OP_X2: begin
        mul_a = 40'(travel_r);
        mul_b = 26'(s16);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign prod_rnd = prod_r + 66'sd32768;
  assign dpos     = prod_rnd[65:16];
  assign npos     = (cmd.op == OP_X2) ? 50'(acc_x_r) + dpos : 50'(acc_y_r) + dpos;
  assign qm_pos   = $signed({1'b0, b_quot[32:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r     <= WHEEL_BASE_RESET;
      prev_l_r <= '0;
      prev_r_r <= '0;
      acc_x_r  <= '0;
      acc_y_r  <= '0;
      head_r   <= '0;
      tbusy_r  <= 1'b0;
      tcnt_r   <= '0;
    end else begin
      if (cfg_we) wb_r <= cfg_wb;
      if (cmd.op == OP_LOAD) begin
        prev_l_r <= in_left;
        prev_r_r <= in_right;
      end
      if (cmd.op == OP_X2) acc_x_r <= sat32(npos);
      if (cmd.op == OP_X3) begin
        acc_y_r <= sat32(npos);
        head_r  <= head_new;
      end
      if (a_start) begin
        tbusy_r <= 1'b1;
        tcnt_r  <= '0;
      end else if (tbusy_r) begin
        tcnt_r <= tcnt_r + 3'd1;
        if (tcnt_r == TRAVEL_LAST) tbusy_r <= 1'b0;
      end
    end
    if (a_start) begin
      tn_r   <= {3'd0, sum_mag, TRAVEL_BIAS};
      tq_r   <= '0;
      trem_r <= '0;
    end else if (tbusy_r) begin
      tn_r   <= {tn_r[39:0], 8'd0};
      tq_r   <= {tq_r[39:0], t_qd};
      trem_r <= t_back[6:0];
    end
    if (mul_en) prod_r <= mul_a * mul_b;
    case (cmd.op)
      OP_LOAD: begin
        sum_neg_r  <= sum[32];
        diff_neg_r <= diff[32];
      end
      OP_QR: begin
        // floor division from the magnitude result
        if (!diff_neg_r) begin
          q_r <= qm_pos;
          r_r <= b_rem;
        end else if (b_rem == 12'd0) begin
          q_r <= -qm_pos;
          r_r <= 12'd0;
        end else begin
          q_r <= -qm_pos - 34'sd1;
          r_r <= wb_eff - b_rem;
        end
      end
      OP_M2: sq_r <= prod_r[63:0];
      OP_M3: sq_r <= sq_r + {prod_r[38:0], 25'd0};
      OP_M4: rg_r <= prod_r[60:0];
      OP_M5: rg_r <= rg_r + {prod_r[35:0], 25'd0};
      OP_SQ: begin
        dunits_r <= t19[51:20];
        travel_r <= sum_neg_r ? -$signed({1'b0, tq_r[37:0]})
                              : $signed({1'b0, tq_r[37:0]});
      end
      OP_RESULT: begin
        ox_r <= acc_x_r;
        oy_r <= acc_y_r;
        oh_r <= head_r;
        oz_r <= to_q15(s30);
        ow_r <= to_q15(c30);
      end
      default: ;
    endcase
  end

  assign status.div_a_busy  = a_busy;
  assign status.div_b_busy  = b_busy;
  assign status.cordic_busy = c_busy;
  assign res_x       = ox_r;
  assign res_y       = oy_r;
  assign res_heading = oh_r;
  assign res_qz      = oz_r;
  assign res_qw      = ow_r;
endmodule

>>> sv/ddo_ctrl.sv
// Odometry sequencer: issues datapath ops and runs both handshakes.
// Depends on ddo_pkg.
`timescale 1ns / 1ps
module ddo_ctrl import ddo_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_DIVQ = 5'd1;
  localparam logic [4:0] ST_QR   = 5'd2;
  localparam logic [4:0] ST_M1   = 5'd3;
  localparam logic [4:0] ST_M2   = 5'd4;
  localparam logic [4:0] ST_M3   = 5'd5;
  localparam logic [4:0] ST_M4   = 5'd6;
  localparam logic [4:0] ST_M5   = 5'd7;
  localparam logic [4:0] ST_RGST = 5'd8;
  localparam logic [4:0] ST_RGW  = 5'd9;
  localparam logic [4:0] ST_SQ   = 5'd10;
  localparam logic [4:0] ST_C1W  = 5'd11;
  localparam logic [4:0] ST_X1   = 5'd12;
  localparam logic [4:0] ST_X2   = 5'd13;
  localparam logic [4:0] ST_X3   = 5'd14;
  localparam logic [4:0] ST_C2W  = 5'd15;
  localparam logic [4:0] ST_OUT  = 5'd16;

  logic [4:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    ov_nxt    = ov_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_DIVQ;
        end
      end
      ST_DIVQ: if (!status.div_b_busy) state_nxt = ST_QR;
      ST_QR: begin
        cmd.op    = OP_QR;
        state_nxt = ST_M1;
      end
      ST_M1: begin
        cmd.op    = OP_M1;
        state_nxt = ST_M2;
      end
      ST_M2: begin
        cmd.op    = OP_M2;
        state_nxt = ST_M3;
      end
      ST_M3: begin
        cmd.op    = OP_M3;
        state_nxt = ST_M4;
      end
      ST_M4: begin
        cmd.op    = OP_M4;
        state_nxt = ST_M5;
      end
      ST_M5: begin
        cmd.op    = OP_M5;
        state_nxt = ST_RGST;
      end
      ST_RGST: begin
        cmd.op    = OP_RGST;
        state_nxt = ST_RGW;
      end
      ST_RGW: begin
        if (!status.div_a_busy && !status.div_b_busy) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = ST_C1W;
      end
      ST_C1W: if (!status.cordic_busy) state_nxt = ST_X1;
      ST_X1: begin
        cmd.op    = OP_X1;
        state_nxt = ST_X2;
      end
      ST_X2: begin
        cmd.op    = OP_X2;
        state_nxt = ST_X3;
      end
      ST_X3: begin
        cmd.op    = OP_X3;
        state_nxt = ST_C2W;
      end
      ST_C2W: if (!status.cordic_busy) state_nxt = ST_OUT;
      ST_OUT: begin
        if (!ov_r || !out_stall) begin
          cmd.op    = OP_RESULT;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
endmodule

>>> tb/tb_diff_drive_odometry_unit.sv
// Self-checking testbench for diff_drive_odometry_unit: a bit-exact pose predictor,
// a clocked driver and monitor, and phased idling, stalls and wheel base writes.
// Depends on ddo_pkg and the RTL top level only.
`timescale 1ns / 1ps
module tb_diff_drive_odometry_unit import ddo_pkg::*; ;

  localparam int STEPS = 16;
  localparam longint unsigned GAIN_Q20 = 64'd358385071201434;
  localparam longint START_X = 64'sd652032874;
  localparam longint HALF_TURN = 64'sh40000000;   // pi
  localparam longint QTR_TURN = 64'sh20000000;    // pi/2
  localparam int LONG_HOLD = 600;
  localparam int PHASE_ITEMS = 300;

  // arctangent table in heading units (pi = 2^30)
  localparam longint ATAN_TBL [0:31] = '{
    268435456, 158466703, 83729454, 42502378, 21333665, 10677233,
    5339919, 2670123, 1335082, 667543, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1, 0, 0};

  typedef struct {
    logic [31:0] left;
    logic [31:0] right;
  } travel_word_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] hdg;
    logic [15:0] qz;
    logic [15:0] qw;
  } pose_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_left_travel_mm = '0;
  logic signed [31:0] in_right_travel_mm = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y;
  logic [31:0] out_heading_angle;
  logic signed [15:0] out_quat_z, out_quat_w;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [11:0] cfg_wheel_base_mm = '0;

  diff_drive_odometry_unit #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_left_travel_mm(in_left_travel_mm), .in_right_travel_mm(in_right_travel_mm),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_heading_angle(out_heading_angle),
    .out_quat_z(out_quat_z), .out_quat_w(out_quat_w),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_wheel_base_mm(cfg_wheel_base_mm)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------
  // Predictor state: mirrors the block's registers
  // ---------------------------------------------------------------
  logic [11:0] wb_mm = WHEEL_BASE_RESET;
  logic [31:0] last_left = '0, last_right = '0;
  logic signed [31:0] pose_x = '0, pose_y = '0;
  logic [31:0] heading = '0;

  travel_word_t travel_q[$];   // words not yet offered
  pose_word_t pose_q[$];       // predicted results in order

  int errors = 0;
  int words_in = 0, words_out = 0;
  int idle_pct = 0, stall_pct = 0;
  int hold_req = 0, hold_seen = 0, hold_left = 0;

  // Rotation-mode CORDIC, Q2.30, angle folded to [-pi/2, pi/2)
  task automatic cordic_sincos(input logic [31:0] ang, output longint s, output longint c);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang[30:0]);
    flip = 1'b0;
    x = START_X;
    y = 0;
    if (z >= HALF_TURN) begin
      z -= HALF_TURN;
      flip = 1'b1;
    end
    if (z >= QTR_TURN) begin
      z -= HALF_TURN;
      flip = ~flip;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_TBL[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_TBL[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic logic [15:0] round_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic logic [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // advance the pose by one accepted travel word, queue the expected result
  task automatic odometry_step(input travel_word_t w);
    logic [31:0] dl32, dr32, dturn, halfmid;
    longint dl, dr, wb, num, travel, diff, q, r, s, c, nx, ny;
    longint unsigned mag, sq;
    pose_word_t p;
    dl32 = w.left - last_left;
    dr32 = w.right - last_right;
    dl = longint'(signed'(dl32));
    dr = longint'(signed'(dr32));
    wb = (wb_mm == 0) ? 1 : longint'(wb_mm);   // zero wheel base acts as 1 mm
    last_left = w.left;
    last_right = w.right;
    // travel in signed Q22.16 metres, rounded half away from zero
    num = (dl + dr) * 65536;
    mag = (num < 0) ? -num : num;
    mag = (mag + 1000) / 2000;
    travel = (num < 0) ? -longint'(mag) : longint'(mag);
    // floor division of the wheel difference by the wheel base
    diff = dr - dl;
    q = diff / wb;
    r = diff % wb;
    if (r < 0) begin
      r += wb;
      q -= 1;
    end
    sq = longint'(unsigned'(q)) * GAIN_Q20 + (longint'(unsigned'(r)) * GAIN_Q20) / wb;
    dturn = 32'((sq + (64'd1 << 19)) >> 20);
    halfmid = 32'((sq + (64'd1 << 20)) >> 21);
    // integrate along the midpoint heading
    cordic_sincos(heading + halfmid, s, c);
    s = (s + 8192) >>> 14;
    c = (c + 8192) >>> 14;
    nx = longint'(pose_x) + ((travel * c + 32768) >>> 16);
    ny = longint'(pose_y) + ((travel * s + 32768) >>> 16);
    pose_x = sat32(nx);
    pose_y = sat32(ny);
    heading += dturn;
    cordic_sincos({1'b0, heading[31:1]}, s, c);
    p.x = pose_x;
    p.y = pose_y;
    p.hdg = heading;
    p.qz = round_q15(s);
    p.qw = round_q15(c);
    pose_q = {pose_q, p};
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("MISMATCH word %0d %s: got %h want %h", words_out, what, got, want);
  endtask

  // ---------------------------------------------------------------
  // Driver: offers queued travel words, random idle gaps
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        travel_word_t w;
        w.left = in_left_travel_mm;
        w.right = in_right_travel_mm;
        odometry_step(w);
        words_in++;
      end
      // a stalled word holds still; otherwise pick the next one or idle
      if (!in_valid || !in_stall) begin
        if (travel_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          travel_word_t n;
          n = travel_q.pop_front();
          in_valid <= 1'b1;
          in_left_travel_mm <= n.left;
          in_right_travel_mm <= n.right;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here so the sender keeps going
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------
  // Monitor: compare each taken result word with the oldest prediction
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pose_q.size() == 0) begin
        report_mismatch("unexpected word", out_pos_x, 32'h0);
      end else begin
        pose_word_t e;
        e = pose_q.pop_front();
        if (out_pos_x !== e.x) report_mismatch("pos_x", out_pos_x, e.x);
        if (out_pos_y !== e.y) report_mismatch("pos_y", out_pos_y, e.y);
        if (out_heading_angle !== e.hdg)
          report_mismatch("heading_angle", out_heading_angle, e.hdg);
        if (out_quat_z !== e.qz) report_mismatch("quat_z", 32'(out_quat_z), 32'(e.qz));
        if (out_quat_w !== e.qw) report_mismatch("quat_w", 32'(out_quat_w), 32'(e.qw));
      end
      words_out++;
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  logic [31:0] cur_left = '0, cur_right = '0;

  task automatic queue_abs(input logic [31:0] l, input logic [31:0] r);
    travel_word_t w;
    w.left = l;
    w.right = r;
    cur_left = l;
    cur_right = r;
    travel_q = {travel_q, w};
  endtask

  task automatic queue_delta(input logic [31:0] dl, input logic [31:0] dr);
    queue_abs(cur_left + dl, cur_right + dr);
  endtask

  // mostly plausible wheel motion, some huge jumps and raw noise
  task automatic queue_random;
    int sel;
    sel = $urandom_range(99);
    if (sel < 75) begin
      queue_delta($urandom_range(800) - 400, $urandom_range(800) - 400);
    end else if (sel < 85) begin
      queue_delta($urandom, $urandom);
    end else if (sel < 93) begin
      // long straight runs push the pose toward saturation
      logic [31:0] d;
      d = $urandom_range(32'h7fffffff);
      if ($urandom_range(1)) d = -d;
      queue_delta(d, d + $urandom_range(8) - 4);
    end else begin
      queue_abs($urandom, $urandom);
    end
  endtask

  task automatic wait_drained;
    while (travel_q.size() > 0 || in_valid || pose_q.size() > 0) @(posedge clk);
  endtask

  task automatic write_wheel_base(input logic [11:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_wheel_base_mm <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    wb_mm = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [11:0] bases [6];
    bases = '{WHEEL_BASE_RESET, 12'd1, 12'd4095, 12'd0, 12'd0, 12'd160};
    bases[4] = $urandom_range(4095);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, straight, spin, wraps, reverse
    queue_abs(32'h0, 32'h0);
    queue_abs(32'd1000, 32'd1000);
    queue_abs(32'd1000, 32'd1389);
    queue_abs(32'd1000, 32'd1000);
    queue_abs(32'h7fffffff, 32'h7fffffff);
    queue_abs(32'h80000000, 32'h80000000);
    queue_abs(32'h80000000, 32'h7fffffff);
    queue_abs(32'h7fffffff, 32'h80000000);
    queue_abs(32'hffffffff, 32'hffffffff);
    queue_abs(32'h0, 32'h0);
    queue_delta(32'h40000000, 32'h40000000);
    queue_delta(32'h40000000, 32'h40000000);
    queue_delta(32'h7fffffff, 32'h7fffffff);
    queue_delta(32'h80000000, 32'h80000000);
    queue_delta(-32'd195, 32'd195);
    queue_delta(32'd195, -32'd195);
    for (int k = 0; k < 8; k++) queue_delta(-32'd100000, 32'd100000);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_wheel_base(bases[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 1 && k == 100) begin
          // sender pause until every result is back
          wait_drained();
        end
        if (ph == 2 && k == 50) begin
          idle_pct = 0;
          hold_req++;   // receiver blocks while the sender keeps offering
        end
        queue_random();
        if (k % 20 == 19) while (travel_q.size() > 4) @(posedge clk);
      end
      wait_drained();
    end

    repeat (250) @(posedge clk);
    $display("Covered %0d travel words and %0d pose results over six wheel base settings",
             words_in, words_out);
    $display("including zero and full-range bases, long stalls and input pauses.");
    if (errors == 0 && pose_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #60ms;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> diff_drive_odometry_unit.f
+incdir+sv
sv/ddo_pkg.sv
sv/ddo_div.sv
sv/ddo_cordic.sv
sv/ddo_datapath.sv
sv/ddo_ctrl.sv
sv/diff_drive_odometry_unit.sv
tb/tb_diff_drive_odometry_unit.sv
